// ===== design/bqf_pkg.sv =====
// Shared types, widths and the microcode program for the biquad filter unit.
// No dependencies; every other design file imports this package.
package bqf_pkg;

	// Field and register widths
	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int STATE_W   = 40;
	localparam int COEF_FRAC = COEF_W - 4;
	localparam int NUM_COEFS = 5;
	localparam int CFG_IDX_W = 3;

	// The state operand is multiplied in two halves: low part unsigned, high part signed
	localparam int LO_W   = STATE_W / 2;
	localparam int HI_W   = STATE_W - LO_W;
	localparam int MOP_W  = HI_W + 1;
	localparam int PROD_W = COEF_W + MOP_W;
	localparam int ACC_W  = COEF_W + STATE_W + 3;

	localparam int STEP_W = 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [STATE_W-1:0]  state_t;
	typedef logic signed [MOP_W-1:0]    mop_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic [STEP_W-1:0]          step_t;

	// Unity gain in Q3.28
	localparam coef_t COEF_ONE = coef_t'(1) <<< COEF_FRAC;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CF_FF0,
		CF_FF1,
		CF_FF2,
		CF_FB1,
		CF_FB2
	} coef_idx_t;

	// Multiplier operand source
	typedef enum logic [1:0] {
		OP_D1,
		OP_D2,
		OP_W
	} opnd_t;

	// Sequencer branch condition
	typedef enum logic [1:0] {
		C_NEXT,
		C_WAIT_IN,
		C_WAIT_OUT,
		C_GOTO
	} cond_t;

	// Datapath strobes for one step
	typedef struct packed {
		logic      issue;
		coef_idx_t coef;
		opnd_t     opnd;
		logic      hi;
		logic      load_x;
		logic      fin_w;
		logic      fin_y;
	} dp_ctrl_t;

	// One control word of the program
	typedef struct packed {
		cond_t    cond;
		step_t    target;
		dp_ctrl_t dp;
	} ucode_t;

	// Build a control word
	function automatic ucode_t uw(cond_t c, step_t t, logic is, coef_idx_t cf, opnd_t op,
			logic hi, logic lx, logic fw, logic fy);
		ucode_t u;
		u.cond      = c;
		u.target    = t;
		u.dp.issue  = is;
		u.dp.coef   = cf;
		u.dp.opnd   = op;
		u.dp.hi     = hi;
		u.dp.load_x = lx;
		u.dp.fin_w  = fw;
		u.dp.fin_y  = fy;
		return u;
	endfunction

	// Program: feedback sum into w, then feedforward sum into y.
	// A product issued in one step is accumulated in the next.
	function automatic ucode_t ucode_rom(step_t pc);
		ucode_t u;
		case (pc)
			4'd0:    u = uw(C_WAIT_IN,  '0, 1'b1, CF_FB1, OP_D1, 1'b0, 1'b1, 1'b0, 1'b0);
			4'd1:    u = uw(C_NEXT,     '0, 1'b1, CF_FB1, OP_D1, 1'b1, 1'b0, 1'b0, 1'b0);
			4'd2:    u = uw(C_NEXT,     '0, 1'b1, CF_FB2, OP_D2, 1'b0, 1'b0, 1'b0, 1'b0);
			4'd3:    u = uw(C_NEXT,     '0, 1'b1, CF_FB2, OP_D2, 1'b1, 1'b0, 1'b0, 1'b0);
			4'd4:    u = uw(C_NEXT,     '0, 1'b0, CF_FB2, OP_D2, 1'b0, 1'b0, 1'b0, 1'b0);
			4'd5:    u = uw(C_NEXT,     '0, 1'b1, CF_FF1, OP_D1, 1'b0, 1'b0, 1'b1, 1'b0);
			4'd6:    u = uw(C_NEXT,     '0, 1'b1, CF_FF1, OP_D1, 1'b1, 1'b0, 1'b0, 1'b0);
			4'd7:    u = uw(C_NEXT,     '0, 1'b1, CF_FF2, OP_D2, 1'b0, 1'b0, 1'b0, 1'b0);
			4'd8:    u = uw(C_NEXT,     '0, 1'b1, CF_FF2, OP_D2, 1'b1, 1'b0, 1'b0, 1'b0);
			4'd9:    u = uw(C_NEXT,     '0, 1'b1, CF_FF0, OP_W,  1'b0, 1'b0, 1'b0, 1'b0);
			4'd10:   u = uw(C_NEXT,     '0, 1'b1, CF_FF0, OP_W,  1'b1, 1'b0, 1'b0, 1'b0);
			4'd11:   u = uw(C_NEXT,     '0, 1'b0, CF_FF0, OP_W,  1'b0, 1'b0, 1'b0, 1'b0);
			4'd12:   u = uw(C_WAIT_OUT, '0, 1'b0, CF_FF0, OP_W,  1'b0, 1'b0, 1'b0, 1'b1);
			default: u = uw(C_GOTO,     '0, 1'b0, CF_FF0, OP_D1, 1'b0, 1'b0, 1'b0, 1'b0);
		endcase
		return u;
	endfunction

endpackage

// ===== design/bqf_in_if.sv =====
// Input sample channel: valid/ready handshake carrying one sample.
// Depends on bqf_pkg for the sample type.
interface bqf_in_if import bqf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

// ===== design/bqf_out_if.sv =====
// Output sample channel: valid/ready handshake carrying one filtered sample.
// Depends on bqf_pkg for the sample type.
interface bqf_out_if import bqf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

// ===== design/bqf_sequencer.sv =====
// Step counter and program ROM of the biquad unit; issues datapath strobes.
// Depends on bqf_pkg for the control word format and the program.
module bqf_sequencer import bqf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_busy,
	output logic     in_ready,
	output dp_ctrl_t ctrl
);

	step_t  pc_q;
	step_t  pc_next;
	ucode_t uword;
	logic   go;

	assign uword = ucode_rom(pc_q);

	// Resolve the branch condition of the current step
	always_comb begin
		go      = 1'b1;
		pc_next = pc_q + step_t'(1);
		case (uword.cond)
			C_NEXT: begin
				go      = 1'b1;
				pc_next = pc_q + step_t'(1);
			end
			C_WAIT_IN: begin
				go      = in_valid;
				pc_next = in_valid ? pc_q + step_t'(1) : pc_q;
			end
			C_WAIT_OUT: begin
				go      = !out_busy;
				pc_next = out_busy ? pc_q : uword.target;
			end
			C_GOTO: begin
				go      = 1'b1;
				pc_next = uword.target;
			end
			default: begin
				go      = 1'b1;
				pc_next = '0;
			end
		endcase
	end

	// Gate the strobes so a stalled step does nothing
	always_comb begin
		ctrl        = uword.dp;
		ctrl.issue  = uword.dp.issue & go;
		ctrl.load_x = uword.dp.load_x & go;
		ctrl.fin_w  = uword.dp.fin_w & go;
		ctrl.fin_y  = uword.dp.fin_y & go;
		in_ready    = (uword.cond == C_WAIT_IN);
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ===== design/bqf_datapath.sv =====
// Shared multiplier, accumulator, round/saturate and delay line of the biquad.
// Depends on bqf_pkg; driven by the strobes of bqf_sequencer.
module bqf_datapath import bqf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_ctrl_t ctrl,
	input  sample_t  x,
	input  coef_t    coefs [NUM_COEFS],
	input  logic     out_ready,
	output logic     out_valid,
	output sample_t  out_sample,
	output logic     out_busy
);

	state_t  d1_q;
	state_t  d2_q;
	state_t  w_q;
	acc_t    acc_q;
	prod_t   prod_s1;
	logic    acc_en_s1;
	logic    hi_s1;
	logic    out_valid_q;
	sample_t out_q;

	state_t  opnd;
	mop_t    mop;
	coef_t   coef;
	acc_t    addend;
	acc_t    rsum;
	state_t  w_sat;
	sample_t y_sat;
	logic    w_fits;
	logic    y_fits;

	// Pick coefficient and operand half
	always_comb begin
		case (ctrl.opnd)
			OP_D1:   opnd = d1_q;
			OP_D2:   opnd = d2_q;
			OP_W:    opnd = w_q;
			default: opnd = d1_q;
		endcase
		coef = coefs[ctrl.coef];
		if (ctrl.hi) begin
			mop = mop_t'($signed(opnd[STATE_W-1:LO_W]));
		end else begin
			mop = mop_t'({1'b0, opnd[LO_W-1:0]});
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= prod_t'(coef) * prod_t'(mop);
		hi_s1   <= ctrl.hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= ctrl.issue;
		end
	end

	// Align the partial product
	assign addend = hi_s1 ? (acc_t'(prod_s1) <<< LO_W) : acc_t'(prod_s1);

	// Accumulate, seed with the input sample, or clear after w is taken
	always_ff @(posedge clk) begin
		if (ctrl.load_x) begin
			acc_q <= acc_t'(x) <<< COEF_FRAC;
		end else if (ctrl.fin_w) begin
			acc_q <= '0;
		end else if (acc_en_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	// Round half up, then saturate to state and sample ranges
	always_comb begin
		rsum   = acc_q + (acc_t'(1) <<< (COEF_FRAC - 1));
		w_fits = (&rsum[ACC_W-1:COEF_FRAC+STATE_W-1]) || !(|rsum[ACC_W-1:COEF_FRAC+STATE_W-1]);
		y_fits = (&rsum[ACC_W-1:COEF_FRAC+SAMPLE_W-1])
			|| !(|rsum[ACC_W-1:COEF_FRAC+SAMPLE_W-1]);
		if (w_fits) begin
			w_sat = rsum[COEF_FRAC+STATE_W-1:COEF_FRAC];
		end else begin
			w_sat = {rsum[ACC_W-1], {(STATE_W-1){!rsum[ACC_W-1]}}};
		end
		if (y_fits) begin
			y_sat = rsum[COEF_FRAC+SAMPLE_W-1:COEF_FRAC];
		end else begin
			y_sat = {rsum[ACC_W-1], {(SAMPLE_W-1){!rsum[ACC_W-1]}}};
		end
	end

	// Hold w for the feedforward pass
	always_ff @(posedge clk) begin
		if (ctrl.fin_w) begin
			w_q <= w_sat;
		end
	end

	// Advance the delay line once the output is formed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (ctrl.fin_y) begin
			d2_q <= d1_q;
			d1_q <= w_q;
		end
	end

	// Output register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fin_y) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin_y) begin
			out_q <= y_sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_q;
	assign out_busy   = out_valid_q & !out_ready;

endmodule

// ===== design/biquad_iir_filter_unit.sv =====
// Direct form II biquad section: per sample w = x + fb1*d1 + fb2*d2 and
// y = ff0*w + ff1*d1 + ff2*d2, both rounded half up from Q3.28 products,
// w saturated to 40 bits and y to 24 bits. A 13-step microprogram drives one
// shared 32x21 multiplier; each 32x40 product takes two passes. The next sample
// is taken as soon as the previous one is in the output register, and not before.
// The output register holds while the sink stalls; a new sample is still
// accepted and computed up to its final step. Coefficients are written through
// cfg_write/cfg_index/cfg_data; the user must write them only while the filter
// is idle, as the block itself does not enforce this. Indexes beyond the last
// coefficient are ignored. Depends on bqf_pkg, the channel interfaces,
// bqf_sequencer and bqf_datapath.
module biquad_iir_filter_unit import bqf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bqf_in_if.sink               x_ch,
	bqf_out_if.source            y_ch,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	coef_t    coef_q [NUM_COEFS];
	dp_ctrl_t ctrl;
	logic     out_busy;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[CF_FF0] <= COEF_ONE;
		end else if (cfg_write && (cfg_index < CFG_IDX_W'(NUM_COEFS))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	bqf_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (x_ch.valid),
		.out_busy (out_busy),
		.in_ready (x_ch.ready),
		.ctrl     (ctrl)
	);

	bqf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.x          (x_ch.sample_in),
		.coefs      (coef_q),
		.out_ready  (y_ch.ready),
		.out_valid  (y_ch.valid),
		.out_sample (y_ch.sample_out),
		.out_busy   (out_busy)
	);

endmodule
